/* rtl/core/gdg_pkg.sv */
// Shared types and constants for the Gregorian date gap unit.
package gdg_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned GAP_W   = 23;

  // Year plus the largest offset used in the leap count (year + 399).
  localparam int unsigned YEXT_W  = YEAR_W + 1;
  // Quotient of an extended year by 100.
  localparam int unsigned QUOT_W  = 8;
  // Leap years below a year, and day-of-year (signed, -1 .. 458).
  localparam int unsigned LEAP_W  = 13;
  localparam int unsigned DOY_W   = 10;
  // Whole-year day term, and the final sum before saturation.
  localparam int unsigned YTERM_W = 24;
  localparam int unsigned SUM_W   = 26;

  // floor(n / 100) == (n * 5243) >> 19 for every n below 43699.
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned MUL_W       = YEXT_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_100   = 13'd5243;
  localparam int unsigned        RECIP_SHIFT = 19;

  localparam logic [6:0] CENTURY   = 7'd100;
  localparam logic [8:0] YEAR_DAYS = 9'd365;

  localparam logic signed [GAP_W-1:0] GAP_MAX = 23'sd4194303;
  localparam logic signed [GAP_W-1:0] GAP_MIN = -23'sd4194304;

  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

  // Days in the whole months before a month, February counted as 28.
  // Month zero counts like January; months past December add 31 each.
  localparam logic [8:0] CUM_DAYS [16] = '{
    9'd0,   9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd396, 9'd427
  };

  typedef struct packed {
    logic [YEAR_W-1:0]       year;
    logic [LEAP_W-1:0]       leaps;
    logic signed [DOY_W-1:0] doy;
  } date_info_t;

endpackage

/* rtl/core/gregorian_date_gap_unit.sv */
// Top level of the Gregorian date gap unit: signed days from one date to another.
//
//   Channel   Handshake            Payload
//   --------  -------------------  ---------------------------------------------
//   input     start / busy         day_first, month_first, year_first,
//                                  day_second, month_second, year_second
//   result    done (one-cycle)     day_gap
//
// Every transaction passes through the four register stages of the pipeline, and
// done rises with day_gap valid in that same cycle.
// A new transaction may be started in every cycle while rst is low; four are
// in flight at most, one in each register stage.
// The synchronous reset clears only the valid bits; busy is high while rst is.
// The receiver cannot stall, so results are never held back and never lost.
//
// Years above MAX_YEAR are clamped to it. A year is a leap year when divisible
// by 400, or by 4 but not by 100. The gap is the day-of-year difference plus
// 365 or 366 for each whole year from the first year up to the second; when
// the first year is not below the second, the year term is zero. The result
// saturates at the limits of a 23-bit signed number.
module gregorian_date_gap_unit #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [gdg_pkg::DAY_W-1:0]         day_first,
  input  logic [gdg_pkg::MONTH_W-1:0]       month_first,
  input  logic [gdg_pkg::YEAR_W-1:0]        year_first,
  input  logic [gdg_pkg::DAY_W-1:0]         day_second,
  input  logic [gdg_pkg::MONTH_W-1:0]       month_second,
  input  logic [gdg_pkg::YEAR_W-1:0]        year_second,
  output logic                              done,
  output logic signed [gdg_pkg::GAP_W-1:0]  day_gap
);

  // The pipeline never stalls, so input is refused only while in reset.
  assign busy = rst;

  logic accept;
  assign accept = start && !busy;

  // One valid bit per pipeline stage; they travel alongside the data.
  logic [3:0] stage_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      stage_valid <= {stage_valid[2:0], accept};
    end
  end

  assign done = stage_valid[3];

  gdg_pkg::date_info_t first_info;
  gdg_pkg::date_info_t second_info;

  // Stages one and two, once for each date.
  gdg_date_front #(
    .MAX_YEAR (MAX_YEAR)
  ) u_front_first (
    .clk   (clk),
    .day   (day_first),
    .month (month_first),
    .year  (year_first),
    .info  (first_info)
  );

  gdg_date_front #(
    .MAX_YEAR (MAX_YEAR)
  ) u_front_second (
    .clk   (clk),
    .day   (day_second),
    .month (month_second),
    .year  (year_second),
    .info  (second_info)
  );

  // Stages three and four: combine the two dates into the day gap.
  gdg_gap_combine u_combine (
    .clk     (clk),
    .first   (first_info),
    .second  (second_info),
    .day_gap (day_gap)
  );

endmodule

/* rtl/core/gdg_date_front.sv */
// Two-stage front end for one date: year clamp, century quotients, leap count, day of year.
module gdg_date_front #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic                        clk,
  input  logic [gdg_pkg::DAY_W-1:0]   day,
  input  logic [gdg_pkg::MONTH_W-1:0] month,
  input  logic [gdg_pkg::YEAR_W-1:0]  year,
  output gdg_pkg::date_info_t         info
);

  localparam logic [16:0] MaxYear = MAX_YEAR[16:0];

  // Stage one: clamped year and its quotients by 100.
  logic [gdg_pkg::YEAR_W-1:0]  year_s1;
  logic [gdg_pkg::DAY_W-1:0]   day_s1;
  logic [gdg_pkg::MONTH_W-1:0] month_s1;
  logic [gdg_pkg::QUOT_W-1:0]  quot_own;
  logic [gdg_pkg::QUOT_W-1:0]  quot_lo;
  logic [gdg_pkg::QUOT_W-1:0]  quot_hi;

  logic [gdg_pkg::YEAR_W-1:0] year_clamped;
  logic [gdg_pkg::YEXT_W-1:0] yext_own;
  logic [gdg_pkg::YEXT_W-1:0] yext_lo;
  logic [gdg_pkg::YEXT_W-1:0] yext_hi;
  logic [gdg_pkg::MUL_W-1:0]  prod_own;
  logic [gdg_pkg::MUL_W-1:0]  prod_lo;
  logic [gdg_pkg::MUL_W-1:0]  prod_hi;

  always_comb begin
    if ({3'b000, year} > MaxYear) begin
      year_clamped = MaxYear[gdg_pkg::YEAR_W-1:0];
    end else begin
      year_clamped = year;
    end
    yext_own = {1'b0, year_clamped};
    yext_lo  = yext_own + gdg_pkg::YEXT_W'(99);
    yext_hi  = yext_own + gdg_pkg::YEXT_W'(399);
    prod_own = gdg_pkg::MUL_W'(yext_own) * gdg_pkg::MUL_W'(gdg_pkg::RECIP_100);
    prod_lo  = gdg_pkg::MUL_W'(yext_lo)  * gdg_pkg::MUL_W'(gdg_pkg::RECIP_100);
    prod_hi  = gdg_pkg::MUL_W'(yext_hi)  * gdg_pkg::MUL_W'(gdg_pkg::RECIP_100);
  end

  always_ff @(posedge clk) begin
    year_s1  <= year_clamped;
    day_s1   <= day;
    month_s1 <= month;
    quot_own <= prod_own[gdg_pkg::RECIP_SHIFT +: gdg_pkg::QUOT_W];
    quot_lo  <= prod_lo[gdg_pkg::RECIP_SHIFT +: gdg_pkg::QUOT_W];
    quot_hi  <= prod_hi[gdg_pkg::RECIP_SHIFT +: gdg_pkg::QUOT_W];
  end

  // Stage two: leap flag, leap years below the year, day of year.
  logic [14:0]                  century_mul;
  logic                         is_century;
  logic                         is_leap;
  logic [gdg_pkg::YEXT_W-1:0]   year_plus3;
  logic [gdg_pkg::LEAP_W-1:0]   leaps_next;
  logic [gdg_pkg::DOY_W-1:0]    doy_sum;
  gdg_pkg::date_info_t          info_next;

  always_comb begin
    century_mul = 15'(quot_own) * 15'(gdg_pkg::CENTURY);
    is_century  = (century_mul == {1'b0, year_s1});
    if (is_century) begin
      is_leap = (quot_own[1:0] == 2'b00);
    end else begin
      is_leap = (year_s1[1:0] == 2'b00);
    end
    year_plus3 = {1'b0, year_s1} + gdg_pkg::YEXT_W'(3);
    leaps_next = year_plus3[gdg_pkg::YEXT_W-1:2]
               - gdg_pkg::LEAP_W'(quot_lo)
               + gdg_pkg::LEAP_W'(quot_hi[gdg_pkg::QUOT_W-1:2]);
    doy_sum = gdg_pkg::DOY_W'(gdg_pkg::CUM_DAYS[month_s1])
            + gdg_pkg::DOY_W'(day_s1)
            + gdg_pkg::DOY_W'(is_leap && (month_s1 > gdg_pkg::MONTH_FEB))
            - gdg_pkg::DOY_W'(1);
    info_next.year  = year_s1;
    info_next.leaps = leaps_next;
    info_next.doy   = $signed(doy_sum);
  end

  always_ff @(posedge clk) begin
    info <= info_next;
  end

endmodule

/* rtl/core/gdg_gap_combine.sv */
// Two-stage back end: whole-year term and day-of-year difference, then sum and saturate.
module gdg_gap_combine (
  input  logic                              clk,
  input  gdg_pkg::date_info_t               first,
  input  gdg_pkg::date_info_t               second,
  output logic signed [gdg_pkg::GAP_W-1:0]  day_gap
);

  logic [gdg_pkg::YTERM_W-1:0]       year_term;
  logic signed [gdg_pkg::DOY_W:0]    doy_diff;

  logic [gdg_pkg::YEAR_W-1:0]        year_span;
  logic [gdg_pkg::YTERM_W-1:0]       year_term_next;

  always_comb begin
    year_span = second.year - first.year;
    if (second.year > first.year) begin
      year_term_next = gdg_pkg::YTERM_W'(year_span) * gdg_pkg::YTERM_W'(gdg_pkg::YEAR_DAYS)
                     + gdg_pkg::YTERM_W'(second.leaps)
                     - gdg_pkg::YTERM_W'(first.leaps);
    end else begin
      year_term_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    year_term <= year_term_next;
    doy_diff  <= (gdg_pkg::DOY_W+1)'(second.doy) - (gdg_pkg::DOY_W+1)'(first.doy);
  end

  logic signed [gdg_pkg::SUM_W-1:0] total;
  logic signed [gdg_pkg::GAP_W-1:0] day_gap_next;

  always_comb begin
    total = $signed({2'b00, year_term})
          + gdg_pkg::SUM_W'(doy_diff);
    if (total > gdg_pkg::SUM_W'(gdg_pkg::GAP_MAX)) begin
      day_gap_next = gdg_pkg::GAP_MAX;
    end else if (total < gdg_pkg::SUM_W'(gdg_pkg::GAP_MIN)) begin
      day_gap_next = gdg_pkg::GAP_MIN;
    end else begin
      day_gap_next = total[gdg_pkg::GAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    day_gap <= day_gap_next;
  end

endmodule
